// ===== sv/leb_pkg.sv =====
// ----------------------------------------------------------------------------
// leb_pkg: shared types and constants for the line edit buffer
// Operation codes, status codes, cell commands and channel payloads.
// ----------------------------------------------------------------------------
package leb_pkg;

  localparam logic [7:0] SpaceByte = 8'h20;

  typedef enum logic [2:0] {
    FuncInsert   = 3'd0,
    FuncDelNext  = 3'd1,
    FuncDelPrev  = 3'd2,
    FuncDelWord  = 3'd3,
    FuncLeft     = 3'd4,
    FuncRight    = 3'd5,
    FuncRead     = 3'd6
  } func_e;

  typedef enum logic [1:0] {
    StatusDone  = 2'd0,
    StatusBound = 2'd1,
    StatusFull  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CellHold = 2'd0,
    CellIns  = 2'd1,
    CellDel  = 2'd2
  } cell_op_e;

  // Broadcast to every cell of the row
  typedef struct packed {
    cell_op_e   op;
    logic [7:0] ch;
  } cell_cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] char_in;
    logic [7:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_char;
    logic [8:0] line_length;
    logic [8:0] cursor_position;
    status_e    status;
  } out_item_t;

endpackage

// ===== sv/leb_chan_if.sv =====
// ----------------------------------------------------------------------------
// leb_chan_if: valid/ready channel
// Carries one payload per transfer; source drives valid and payload.
// ----------------------------------------------------------------------------
interface leb_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/leb_cell.sv =====
// ----------------------------------------------------------------------------
// leb_cell: one byte position of the line
// Holds a byte and takes it from a neighbor when the row shifts.
// ----------------------------------------------------------------------------
module leb_cell #(
  parameter int PW  = 8,
  parameter int IDX = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  leb_pkg::cell_cmd_t  cmd_i,
  input  logic [PW-1:0]       pos_i,
  input  logic [PW-1:0]       sel_pos_i,
  input  logic [7:0]          left_i,
  input  logic [7:0]          right_i,
  output logic [7:0]          data_o,
  output logic [7:0]          sel_data_o
);

  localparam logic [PW-1:0] Here = PW'(IDX);

  logic [7:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    unique case (cmd_i.op)
      leb_pkg::CellHold: data_d = data_q;
      leb_pkg::CellIns: begin
        if (Here == pos_i) begin
          data_d = cmd_i.ch;
        end else if (Here > pos_i) begin
          data_d = left_i;
        end
      end
      leb_pkg::CellDel: begin
        if (Here >= pos_i) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= 8'h00;
    end else begin
      data_q <= data_d;
    end
  end

  assign data_o     = data_q;
  // one-hot pick: only the addressed cell drives nonzero
  assign sel_data_o = (Here == sel_pos_i) ? data_q : 8'h00;

endmodule

// ===== sv/leb_ctrl.sv =====
// ----------------------------------------------------------------------------
// leb_ctrl: operation sequencer for the line edit buffer
// Tracks length and cursor, issues shift commands to the cell row and
// holds the result register.
// ----------------------------------------------------------------------------
module leb_ctrl #(
  parameter int CAPACITY = 256,
  localparam int PW = $clog2(CAPACITY),
  localparam int LW = $clog2(CAPACITY + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  leb_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output leb_pkg::out_item_t  out_item_o,
  input  logic [7:0]          sel_data_i,
  output leb_pkg::cell_cmd_t  cmd_o,
  output logic [PW-1:0]       pos_o,
  output logic [PW-1:0]       sel_pos_o
);

  typedef enum logic [2:0] {
    StIdle,
    StReadGet,
    StWordFirst,
    StWordWait,
    StWordChk,
    StResult
  } state_e;

  state_e             state_q, state_d;
  logic [LW-1:0]      len_q, len_d;
  logic [LW-1:0]      cur_q, cur_d;
  logic [LW-1:0]      cur_m1;
  leb_pkg::status_e   status_q, status_d;
  logic [7:0]         rchar_q, rchar_d;
  logic [7:0]         sel_q;
  logic               rd_ok_q, rd_ok_d;
  logic               on_space_q, on_space_d;
  logic               out_valid_q, out_valid_d;
  leb_pkg::out_item_t out_item_q, out_item_d;
  leb_pkg::func_e     func;
  logic               at_end;
  logic               full;

  assign func   = leb_pkg::func_e'(in_item_i.func);
  assign cur_m1 = cur_q - LW'(1);
  assign at_end = (cur_q >= len_q);
  assign full   = (len_q == LW'(CAPACITY));

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    cur_d       = cur_q;
    status_d    = status_q;
    rchar_d     = rchar_q;
    rd_ok_d     = rd_ok_q;
    on_space_d  = on_space_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_item_d  = out_item_q;
    cmd_o.op    = leb_pkg::CellHold;
    cmd_o.ch    = in_item_i.char_in;
    pos_o       = cur_q[PW-1:0];
    sel_pos_o   = cur_m1[PW-1:0];

    unique case (state_q)
      StIdle: begin
        if (func == leb_pkg::FuncRead) begin
          sel_pos_o = PW'(in_item_i.read_index);
        end
        if (in_valid_i) begin
          status_d = leb_pkg::StatusDone;
          rchar_d  = 8'h00;
          state_d  = StResult;
          unique case (func)
            leb_pkg::FuncInsert: begin
              if (full) begin
                status_d = leb_pkg::StatusFull;
              end else begin
                cmd_o.op = leb_pkg::CellIns;
                len_d    = len_q + LW'(1);
                cur_d    = cur_q + LW'(1);
              end
            end
            leb_pkg::FuncDelNext: begin
              if (at_end) begin
                status_d = leb_pkg::StatusBound;
              end else begin
                cmd_o.op = leb_pkg::CellDel;
                len_d    = len_q - LW'(1);
              end
            end
            leb_pkg::FuncDelPrev: begin
              if (cur_q == '0) begin
                status_d = leb_pkg::StatusBound;
              end else begin
                cmd_o.op = leb_pkg::CellDel;
                pos_o    = cur_m1[PW-1:0];
                len_d    = len_q - LW'(1);
                cur_d    = cur_m1;
              end
            end
            leb_pkg::FuncDelWord: begin
              if (cur_q == '0) begin
                status_d = leb_pkg::StatusBound;
              end else begin
                state_d = StWordFirst;
              end
            end
            leb_pkg::FuncLeft: begin
              if (cur_q == '0) begin
                status_d = leb_pkg::StatusBound;
              end else begin
                cur_d = cur_m1;
              end
            end
            leb_pkg::FuncRight: begin
              if (at_end) begin
                status_d = leb_pkg::StatusBound;
              end else begin
                cur_d = cur_q + LW'(1);
              end
            end
            leb_pkg::FuncRead: begin
              rd_ok_d = (in_item_i.read_index < len_q);
              state_d = StReadGet;
            end
            default: ;
          endcase
        end
      end
      StReadGet: begin
        rchar_d = rd_ok_q ? sel_q : 8'h00;
        state_d = StResult;
      end
      StWordFirst: begin
        // byte before the cursor decides which kind of run goes
        on_space_d = (sel_q == leb_pkg::SpaceByte);
        cmd_o.op   = leb_pkg::CellDel;
        pos_o      = cur_m1[PW-1:0];
        len_d      = len_q - LW'(1);
        cur_d      = cur_m1;
        state_d    = StWordWait;
      end
      StWordWait: begin
        state_d = StWordChk;
      end
      StWordChk: begin
        if ((cur_q != '0) && ((sel_q == leb_pkg::SpaceByte) == on_space_q)) begin
          cmd_o.op = leb_pkg::CellDel;
          pos_o    = cur_m1[PW-1:0];
          len_d    = len_q - LW'(1);
          cur_d    = cur_m1;
          state_d  = StWordWait;
        end else begin
          state_d = StResult;
        end
      end
      StResult: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d                = 1'b1;
          out_item_d.read_char       = rchar_q;
          out_item_d.line_length     = 9'(len_q);
          out_item_d.cursor_position = 9'(cur_q);
          out_item_d.status          = status_q;
          state_d                    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      len_q       <= '0;
      cur_q       <= '0;
      status_q    <= leb_pkg::StatusDone;
      rchar_q     <= 8'h00;
      sel_q       <= 8'h00;
      rd_ok_q     <= 1'b0;
      on_space_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      cur_q       <= cur_d;
      status_q    <= status_d;
      rchar_q     <= rchar_d;
      sel_q       <= sel_data_i;
      rd_ok_q     <= rd_ok_d;
      on_space_q  <= on_space_d;
      out_valid_q <= out_valid_d;
      out_item_q  <= out_item_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTHESIS
  a_cur_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q <= len_q)
    else $error("cursor past line length");

  a_len_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LW'(CAPACITY))
    else $error("line length above capacity");

  a_del_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == leb_pkg::CellDel |=> len_q == $past(len_q) - LW'(1))
    else $error("delete did not shrink the line by one");

  a_ins_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == leb_pkg::CellIns |=> len_q == $past(len_q) + LW'(1))
    else $error("insert did not grow the line by one");

  a_result_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StResult && out_valid_q && !out_ready_i) |=> state_q == StResult)
    else $error("result dropped while output slot busy");
`endif

endmodule

// ===== sv/line_edit_buffer.sv =====
// Sequence: insert, delete and cursor moves go from idle straight to the result
// state; a read passes a read-get state first, and a word delete that removes N
// bytes (up to CAPACITY) passes a first-byte state, then loops on wait and check.
// Flow: one operation at a time; the result is registered once the output slot
// is free, and the input is ready again as the result enters that register.
// Reset: asynchronous, clears every byte cell, the length and the cursor.
// ----------------------------------------------------------------------------
// line_edit_buffer: editable text line held in a row of shifting byte cells
// Insert and delete shift the tail of the row by one position per step.
// ----------------------------------------------------------------------------
module line_edit_buffer #(
  parameter int CAPACITY = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  leb_chan_if.sink    in_i,
  leb_chan_if.source  out_o
);

  localparam int PW = $clog2(CAPACITY);

  leb_pkg::cell_cmd_t cmd;
  logic [PW-1:0]      pos;
  logic [PW-1:0]      sel_pos;
  logic [7:0]         cell_data [CAPACITY];
  logic [7:0]         cell_sel  [CAPACITY];
  logic [7:0]         sel_or;

  leb_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_item_i   (in_i.payload),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_item_o  (out_o.payload),
    .sel_data_i  (sel_or),
    .cmd_o       (cmd),
    .pos_o       (pos),
    .sel_pos_o   (sel_pos)
  );

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [7:0] left;
    logic [7:0] right;

    if (g == 0) begin : g_first
      assign left = 8'h00;
    end else begin : g_mid_l
      assign left = cell_data[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right = 8'h00;
    end else begin : g_mid_r
      assign right = cell_data[g+1];
    end

    leb_cell #(
      .PW  (PW),
      .IDX (g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .pos_i      (pos),
      .sel_pos_i  (sel_pos),
      .left_i     (left),
      .right_i    (right),
      .data_o     (cell_data[g]),
      .sel_data_o (cell_sel[g])
    );
  end

  // at most one cell is addressed, so an OR collects its byte
  always_comb begin
    sel_or = 8'h00;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_or = sel_or | cell_sel[i];
    end
  end

endmodule

// ===== bench/line_edit_buffer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_edit_buffer_tb: self-checking bench for the line edit buffer
// Drives editing operations over the valid/ready input channel, mirrors the
// line, length and cursor in a local model and checks every result transfer.
// A directed table covers the boundaries and a full line, then random runs of
// typing, editing, erasing and filling follow, with gaps and one long stall.
// ----------------------------------------------------------------------------
module line_edit_buffer_tb;

  localparam int LineCap     = 256;
  localparam int RandomOps   = 1200;
  localparam int HoldCycles  = 400;
  localparam int StallLimit  = 8000;
  localparam int DrainCycles = 2 * LineCap + 4;
  localparam int MaxReports  = 10;

  // Func code with no operation behind it
  localparam logic [2:0] FuncUnused = 3'd7;

  typedef enum int {MixType, MixEdit, MixErase, MixFill} mix_e;

  typedef struct {
    logic [2:0]         func;
    logic [7:0]         ch;
    logic [7:0]         idx;
    int                 reps;
    bit                 has_want;
    leb_pkg::out_item_t want;
  } edit_row_t;

  typedef struct {
    bit                 has_want;
    leb_pkg::out_item_t want;
  } fixed_want_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  leb_chan_if #(.payload_t(leb_pkg::in_item_t))  in_ch ();
  leb_chan_if #(.payload_t(leb_pkg::out_item_t)) out_ch ();

  line_edit_buffer #(.CAPACITY(LineCap)) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Mirror of the line
  logic [7:0] line_buf [LineCap];
  int         line_len = 0;
  int         cur_pos  = 0;

  leb_pkg::out_item_t edit_results_q [$];
  fixed_want_t        fixed_want_q [$];
  int                 fail_cnt     = 0;
  int                 stall_cycles = 0;
  bit                 tx_gaps      = 1'b1;
  bit                 rx_gaps      = 1'b1;
  bit                 hold_req     = 1'b0;

  initial begin
    foreach (line_buf[i]) line_buf[i] = 8'h00;
  end

  // Directed table: typed expectations only where obvious
  edit_row_t dir_rows [25] = '{
    '{leb_pkg::FuncRead, 8'h00, 8'h00, 1, 1'b1,
      '{8'h00, 9'd0, 9'd0, leb_pkg::StatusDone}},
    '{leb_pkg::FuncLeft, 8'h00, 8'h00, 1, 1'b1,
      '{8'h00, 9'd0, 9'd0, leb_pkg::StatusBound}},
    '{leb_pkg::FuncRight, 8'h00, 8'h00, 1, 1'b1,
      '{8'h00, 9'd0, 9'd0, leb_pkg::StatusBound}},
    '{leb_pkg::FuncDelPrev, 8'h00, 8'h00, 1, 1'b1,
      '{8'h00, 9'd0, 9'd0, leb_pkg::StatusBound}},
    '{leb_pkg::FuncDelWord, 8'h00, 8'h00, 1, 1'b1,
      '{8'h00, 9'd0, 9'd0, leb_pkg::StatusBound}},
    '{leb_pkg::FuncDelNext, 8'h00, 8'h00, 1, 1'b1,
      '{8'h00, 9'd0, 9'd0, leb_pkg::StatusBound}},
    '{FuncUnused, 8'hff, 8'hff, 1, 1'b1,
      '{8'h00, 9'd0, 9'd0, leb_pkg::StatusDone}},
    '{leb_pkg::FuncInsert, 8'h78, 8'h00, LineCap, 1'b0,
      '{8'h00, 9'd0, 9'd0, leb_pkg::StatusDone}},
    '{leb_pkg::FuncInsert, 8'h5a, 8'h00, 1, 1'b1,
      '{8'h00, 9'd256, 9'd256, leb_pkg::StatusFull}},
    '{leb_pkg::FuncRight, 8'h00, 8'h00, 1, 1'b1,
      '{8'h00, 9'd256, 9'd256, leb_pkg::StatusBound}},
    '{leb_pkg::FuncDelNext, 8'h00, 8'h00, 1, 1'b1,
      '{8'h00, 9'd256, 9'd256, leb_pkg::StatusBound}},
    '{leb_pkg::FuncRead, 8'h00, 8'hff, 1, 1'b1,
      '{8'h78, 9'd256, 9'd256, leb_pkg::StatusDone}},
    '{leb_pkg::FuncDelWord, 8'h00, 8'h00, 1, 1'b1,
      '{8'h00, 9'd0, 9'd0, leb_pkg::StatusDone}},
    '{leb_pkg::FuncInsert, 8'h00, 8'h00, 1, 1'b1,
      '{8'h00, 9'd1, 9'd1, leb_pkg::StatusDone}},
    '{leb_pkg::FuncInsert, 8'hff, 8'h00, 1, 1'b1,
      '{8'h00, 9'd2, 9'd2, leb_pkg::StatusDone}},
    '{leb_pkg::FuncInsert, leb_pkg::SpaceByte, 8'h00, 2, 1'b0,
      '{8'h00, 9'd0, 9'd0, leb_pkg::StatusDone}},
    '{leb_pkg::FuncInsert, 8'h61, 8'h00, 1, 1'b0,
      '{8'h00, 9'd0, 9'd0, leb_pkg::StatusDone}},
    '{leb_pkg::FuncLeft, 8'h00, 8'h00, 1, 1'b0,
      '{8'h00, 9'd0, 9'd0, leb_pkg::StatusDone}},
    '{leb_pkg::FuncDelWord, 8'h00, 8'h00, 1, 1'b0,
      '{8'h00, 9'd0, 9'd0, leb_pkg::StatusDone}},
    '{leb_pkg::FuncRead, 8'h00, 8'h01, 1, 1'b0,
      '{8'h00, 9'd0, 9'd0, leb_pkg::StatusDone}},
    '{leb_pkg::FuncRight, 8'h00, 8'h00, 1, 1'b0,
      '{8'h00, 9'd0, 9'd0, leb_pkg::StatusDone}},
    '{leb_pkg::FuncDelPrev, 8'h00, 8'h00, 1, 1'b0,
      '{8'h00, 9'd0, 9'd0, leb_pkg::StatusDone}},
    '{leb_pkg::FuncLeft, 8'h00, 8'h00, 1, 1'b0,
      '{8'h00, 9'd0, 9'd0, leb_pkg::StatusDone}},
    '{leb_pkg::FuncDelNext, 8'h00, 8'h00, 1, 1'b0,
      '{8'h00, 9'd0, 9'd0, leb_pkg::StatusDone}},
    '{leb_pkg::FuncRead, 8'h00, 8'h00, 1, 1'b0,
      '{8'h00, 9'd0, 9'd0, leb_pkg::StatusDone}}
  };

  // Remove [lo, hi) and close the gap; freed tail bytes go back to zero
  function automatic void drop_span(int lo, int hi);
    int gap;
    int i;
    gap = hi - lo;
    for (i = hi; i < line_len; i++) line_buf[i - gap] = line_buf[i];
    for (i = line_len - gap; i < line_len; i++) line_buf[i] = 8'h00;
    line_len -= gap;
  endfunction

  function automatic leb_pkg::out_item_t apply_edit(leb_pkg::in_item_t op);
    leb_pkg::out_item_t res;
    int                 i;
    int                 stop;
    logic               on_space;
    res = '0;
    case (op.func)
      leb_pkg::FuncInsert: begin
        if (line_len >= LineCap) begin
          res.status = leb_pkg::StatusFull;
        end else begin
          for (i = line_len; i > cur_pos; i--) line_buf[i] = line_buf[i - 1];
          line_buf[cur_pos] = op.char_in;
          line_len++;
          cur_pos++;
        end
      end
      leb_pkg::FuncDelNext: begin
        if (cur_pos >= line_len) res.status = leb_pkg::StatusBound;
        else drop_span(cur_pos, cur_pos + 1);
      end
      leb_pkg::FuncDelPrev: begin
        if (cur_pos == 0) begin
          res.status = leb_pkg::StatusBound;
        end else begin
          drop_span(cur_pos - 1, cur_pos);
          cur_pos--;
        end
      end
      leb_pkg::FuncDelWord: begin
        if (cur_pos == 0) begin
          res.status = leb_pkg::StatusBound;
        end else begin
          // erase the run of the same class (space or not) left of the cursor
          on_space = (line_buf[cur_pos - 1] == leb_pkg::SpaceByte);
          stop = cur_pos;
          while (stop != 0 && ((line_buf[stop - 1] == leb_pkg::SpaceByte) == on_space))
            stop--;
          drop_span(stop, cur_pos);
          cur_pos = stop;
        end
      end
      leb_pkg::FuncLeft: begin
        if (cur_pos == 0) res.status = leb_pkg::StatusBound;
        else cur_pos--;
      end
      leb_pkg::FuncRight: begin
        if (cur_pos >= line_len) res.status = leb_pkg::StatusBound;
        else cur_pos++;
      end
      leb_pkg::FuncRead: begin
        if (int'(op.read_index) < line_len) res.read_char = line_buf[op.read_index];
      end
      default: ;
    endcase
    res.line_length     = 9'(line_len);
    res.cursor_position = 9'(cur_pos);
    return res;
  endfunction

  function automatic leb_pkg::in_item_t pick_op(mix_e mix);
    leb_pkg::in_item_t op;
    int                r;
    int                top;
    r = int'($urandom_range(99));
    case (mix)
      MixType:
        op.func = r < 70 ? leb_pkg::FuncInsert : r < 78 ? leb_pkg::FuncLeft :
                  r < 84 ? leb_pkg::FuncRight : r < 92 ? leb_pkg::FuncDelPrev :
                  leb_pkg::FuncRead;
      MixErase:
        op.func = r < 25 ? leb_pkg::FuncDelPrev : r < 45 ? leb_pkg::FuncDelWord :
                  r < 60 ? leb_pkg::FuncDelNext : r < 70 ? leb_pkg::FuncLeft :
                  r < 80 ? leb_pkg::FuncRight : r < 90 ? leb_pkg::FuncInsert :
                  leb_pkg::FuncRead;
      MixFill:
        op.func = r < 95 ? leb_pkg::FuncInsert : leb_pkg::FuncRead;
      default:
        op.func = r < 2 ? FuncUnused : 3'($urandom_range(6));
    endcase
    r = int'($urandom_range(99));
    op.char_in = r < 35 ? leb_pkg::SpaceByte : r < 75 ? 8'($urandom_range(8'h7a, 8'h61)) :
                 8'($urandom_range(255));
    top = line_len > 255 ? 255 : line_len;
    op.read_index = $urandom_range(99) < 70 ? 8'($urandom_range(top)) : 8'($urandom_range(255));
    return op;
  endfunction

  // Offer one operation and return at the edge of its transfer
  task automatic send_edit(leb_pkg::in_item_t op, bit has_want, leb_pkg::out_item_t want);
    if (tx_gaps && $urandom_range(99) < 15) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    fixed_want_q.push_back(fixed_want_t'{has_want, want});
    in_ch.valid   <= 1'b1;
    in_ch.payload <= op;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  // Prediction on input transfers, checking on output transfers, watchdog
  always @(posedge clk_i) begin : scoreboard
    leb_pkg::out_item_t pred;
    leb_pkg::out_item_t want;
    fixed_want_t        fw;
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      pred = apply_edit(in_ch.payload);
      fw = fixed_want_q.pop_front();
      edit_results_q.push_back(fw.has_want ? fw.want : pred);
    end
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (edit_results_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MaxReports)
          $display("%0t: result with nothing expected: %p", $realtime, out_ch.payload);
      end else begin
        want = edit_results_q.pop_front();
        if (out_ch.payload.read_char !== want.read_char ||
            out_ch.payload.line_length !== want.line_length ||
            out_ch.payload.cursor_position !== want.cursor_position ||
            out_ch.payload.status !== want.status) begin
          fail_cnt++;
          if (fail_cnt <= MaxReports)
            $display("%0t: mismatch exp char %h len %0d cur %0d st %0d, got %h %0d %0d %0d",
                     $realtime, want.read_char, want.line_length, want.cursor_position,
                     want.status, out_ch.payload.read_char, out_ch.payload.line_length,
                     out_ch.payload.cursor_position, out_ch.payload.status);
        end
      end
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles == StallLimit) begin
      $display("line_edit_buffer_tb: FAIL");
      $finish;
    end
  end

  initial begin : rx_drive
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(rx_gaps && $urandom_range(99) < 15);
      end
    end
  end

  initial begin : stimulus
    int                k;
    int                n;
    int                run_left;
    int                r;
    bit                held;
    mix_e              mix;
    leb_pkg::in_item_t op;
    in_ch.valid   <= 1'b0;
    in_ch.payload <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      for (k = 0; k < dir_rows[i].reps; k++) begin
        op.func       = dir_rows[i].func;
        op.char_in    = dir_rows[i].ch;
        op.read_index = dir_rows[i].idx;
        send_edit(op, dir_rows[i].has_want, dir_rows[i].want);
      end
    end

    n        = 0;
    run_left = 0;
    held     = 1'b0;
    mix      = MixEdit;
    while (n < RandomOps) begin
      if (run_left == 0) begin
        r = int'($urandom_range(99));
        if (r < 8) begin
          mix      = MixFill;
          run_left = 300;
        end else begin
          mix      = r < 38 ? MixType : r < 70 ? MixEdit : MixErase;
          run_left = int'($urandom_range(60, 20));
        end
      end
      run_left--;
      // steady stretch with no gaps on either side
      tx_gaps = !(n >= 500 && n < 800);
      rx_gaps = tx_gaps;
      if (n >= 1000 && !held) begin
        held     = 1'b1;
        hold_req = 1'b1;
      end
      op = pick_op(mix);
      send_edit(op, 1'b0, '0);
      if (op.func != FuncUnused) n++;
    end
    in_ch.valid <= 1'b0;

    while (edit_results_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_cnt == 0 && edit_results_q.size() == 0) begin
      $display("line_edit_buffer_tb: PASS");
    end else begin
      $display("line_edit_buffer_tb: FAIL");
    end
    $finish;
  end

endmodule
